[rtl/core/wma_pkg.sv]
// Shared constants and types for the weighted moving average core.
`timescale 1ns / 1ps
package wma_pkg;

   localparam int SAMPLE_W      = 16;
   localparam int CFG_W         = 6;
   localparam int DEPTH_DEFAULT = 32;

   localparam logic [CFG_W-1:0] WINDOW_RESET = 6'd5;

   localparam logic [1:0] OP_NOP = 2'd0;
   localparam logic [1:0] OP_CLR = 2'd1;
   localparam logic [1:0] OP_MAC = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   typedef struct packed {
      logic [1:0] op;
      logic       data_valid;
   } alu_ctrl_type;

endpackage

[rtl/core/wma_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module wma_ram #(
   parameter int Width = 16,
   parameter int Depth = 32,
   parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [Width-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/wma_alu.sv]
// Shared arithmetic unit: multiply-accumulate of taps, then restoring divide steps.
`timescale 1ns / 1ps
module wma_alu #(
   parameter int Depth = wma_pkg::DEPTH_DEFAULT,
   parameter int WeightW = $clog2(Depth + 1),
   parameter int DivW = $clog2(Depth * (Depth + 1) / 2 + 1),
   parameter int AccW = wma_pkg::SAMPLE_W + DivW
) (
   input  logic                          clock,
   input  wma_pkg::alu_ctrl_type         ctrl,
   input  logic [WeightW-1:0]            weight,
   input  logic [wma_pkg::SAMPLE_W-1:0]  data,
   output logic [AccW-1:0]               acc
);
   import wma_pkg::*;

   logic [AccW-1:0]             acc_ff, acc_in;
   logic [DivW-1:0]             rem_ff, rem_in;
   logic [DivW-1:0]             div_ff, div_in;
   logic [SAMPLE_W-1:0]         tap;
   logic [SAMPLE_W+WeightW-1:0] prod;
   logic [DivW:0]               shifted;
   logic [DivW:0]               diff;
   logic                        fits;

   assign tap     = ctrl.data_valid ? data : '0;
   assign prod    = tap * weight;
   assign shifted = {rem_ff, acc_ff[AccW-1]};
   assign diff    = shifted - {1'b0, div_ff};
   assign fits    = shifted >= {1'b0, div_ff};

   always_comb begin
      acc_in = acc_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      case (ctrl.op)
         OP_CLR: begin
            acc_in = '0;
            rem_in = '0;
            div_in = '0;
         end
         OP_MAC: begin
            acc_in = acc_ff + AccW'(prod);
            div_in = div_ff + DivW'(weight);
         end
         OP_DIV: begin
            acc_in = {acc_ff[AccW-2:0], fits};
            rem_in = fits ? diff[DivW-1:0] : shifted[DivW-1:0];
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign acc = acc_ff;

endmodule

[rtl/core/weighted_moving_average_core.sv]
// Top level: linearly weighted moving average over a circular sample history.
//
//   Channel  Direction  Contents
//   req      in         tdata[15:0] sample
//   rsp      out        tdata[15:0] average
//   csr      in         data[5:0] window_length (clamped to 1..Depth)
//
// Each item runs one MAC per tap of the clamped window through the single history
// RAM read port, then one restoring divide step per accumulator bit (AccW = 16 +
// divisor bits) in the shared ALU.
// req_tready is high only while idle; a result waits in the output register.
// Reset is synchronous; history valid bits clear at once, so no clearing pass.
`timescale 1ns / 1ps
module weighted_moving_average_core #(
   parameter int Depth = wma_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [15:0]                   req_tdata,  // [15:0] sample
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [15:0]                   rsp_tdata,  // [15:0] average
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [wma_pkg::CFG_W-1:0]     csr_data    // [5:0] window_length
);
   import wma_pkg::*;

   localparam int AddrW   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int WeightW = $clog2(Depth + 1);
   localparam int DivW    = $clog2(Depth * (Depth + 1) / 2 + 1);
   localparam int AccW    = SAMPLE_W + DivW;
   localparam int CntW    = $clog2(AccW);
   localparam int CmpW    = (WeightW > CFG_W) ? WeightW : CFG_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_DRAIN = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [CFG_W-1:0]    window_ff, window_in;
   logic [AddrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AddrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [WeightW-1:0]  weight_ff, weight_in;
   logic [WeightW-1:0]  tap_weight_ff, tap_weight_in;
   logic                tap_valid_ff, tap_valid_in;
   logic                mac_pend_ff, mac_pend_in;
   logic [CntW-1:0]     cnt_ff, cnt_in;
   logic [Depth-1:0]    valid_ff, valid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_data_ff, rsp_data_in;

   logic                accept;
   logic                load_rsp;
   logic [CmpW-1:0]     window_ext;
   logic [WeightW-1:0]  window_clamped;
   logic [SAMPLE_W-1:0] ram_rd_data;
   logic [AccW-1:0]     acc;
   alu_ctrl_type        alu_ctrl;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;
   assign load_rsp   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   assign window_ext = CmpW'(window_ff);

   always_comb begin
      if (window_ext == '0) begin
         window_clamped = WeightW'(1);
      end else if (window_ext > CmpW'(Depth)) begin
         window_clamped = WeightW'(Depth);
      end else begin
         window_clamped = window_ext[WeightW-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      window_in     = (csr_valid && csr_ready) ? csr_data : window_ff;
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      weight_in     = weight_ff;
      cnt_in        = cnt_ff;
      valid_in      = valid_ff;
      tap_weight_in = weight_ff;
      tap_valid_in  = valid_ff[rd_ptr_ff];
      mac_pend_in   = (state_ff == S_READ);
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_data_in   = rsp_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               valid_in[wr_ptr_ff] = 1'b1;
               rd_ptr_in = wr_ptr_ff;
               wr_ptr_in = (wr_ptr_ff == AddrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
               weight_in = window_clamped;
               state_in  = S_READ;
            end
         end
         S_READ: begin
            rd_ptr_in = (rd_ptr_ff == '0) ? AddrW'(Depth - 1) : rd_ptr_ff - 1'b1;
            weight_in = weight_ff - 1'b1;
            if (weight_ff == WeightW'(1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            cnt_in   = CntW'(AccW - 1);
            state_in = S_DIV;
         end
         S_DIV: begin
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = acc[SAMPLE_W-1:0];
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      alu_ctrl.data_valid = tap_valid_ff;
      if (mac_pend_ff) begin
         alu_ctrl.op = OP_MAC;
      end else if (state_ff == S_DIV) begin
         alu_ctrl.op = OP_DIV;
      end else if (accept) begin
         alu_ctrl.op = OP_CLR;
      end else begin
         alu_ctrl.op = OP_NOP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         window_ff    <= WINDOW_RESET;
         wr_ptr_ff    <= '0;
         valid_ff     <= '0;
         mac_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         wr_ptr_ff    <= wr_ptr_in;
         valid_ff     <= valid_in;
         mac_pend_ff  <= mac_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff     <= rd_ptr_in;
      weight_ff     <= weight_in;
      tap_weight_ff <= tap_weight_in;
      tap_valid_ff  <= tap_valid_in;
      cnt_ff        <= cnt_in;
      rsp_data_ff   <= rsp_data_in;
   end

   wma_ram #(
      .Width (SAMPLE_W),
      .Depth (Depth),
      .AddrW (AddrW)
   ) u_history (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wr_ptr_ff),
      .wr_data (req_tdata),
      .rd_en   (state_ff == S_READ),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   wma_alu #(
      .Depth   (Depth),
      .WeightW (WeightW),
      .DivW    (DivW),
      .AccW    (AccW)
   ) u_alu (
      .clock  (clock),
      .ctrl   (alu_ctrl),
      .weight (tap_weight_ff),
      .data   (ram_rd_data),
      .acc    (acc)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
